### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] key;
  } spq_op_t;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    logic                      le;
    logic                      gt;
    logic signed [VALUE_W-1:0] value;
  } spq_link_t;

endpackage

### hw/rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying insert and remove requests.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [spq_pkg::VALUE_W-1:0]  value_in;

  modport source (output valid, output req_type, output value_in, input ready);
  modport sink   (input valid, input req_type, input value_in, output ready);
endinterface

### hw/rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::VALUE_W-1:0]  value_out;
  logic [1:0]                          status;
  logic [spq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, output value_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input value_out, input status, input occupancy,
                  output ready);
endinterface

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry, compares it with the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                                clk,
  input  logic                                valid,
  input  spq_pkg::spq_op_t                    op,
  input  spq_pkg::spq_link_t                  left,
  input  logic signed [spq_pkg::VALUE_W-1:0]  right_value,
  output spq_pkg::spq_link_t                  link
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic                      gt;
  logic                      le;

  assign gt = valid && (value > op.key);
  assign le = valid && !gt;

  assign link.le    = le;
  assign link.gt    = gt;
  assign link.value = value;

  // An insert lands after every entry less than or equal to the key.
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (left.gt) begin
        value <= left.value;
      end else if (!le && left.le) begin
        value <= op.key;
      end
    end else if (op.rem) begin
      value <= right_value;
    end
  end

endmodule

### hw/rtl/sorted_min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted minimum priority queue
// Row of cells kept in ascending order; head of the list is cell 0.
//
//   Channel  Dir  Payload                          Beat
//   req      in   req_type, value_in               one request
//   rsp      out  value_out, status, occupancy     one result per request
//
// While the output register can take a result, one request is taken per
// cycle; every cell compares with the key at once and shifts with its
// neighbors in the same cycle; the result is held in the output register.
// A new request is taken while that register is empty or being drained.
// Reset clears the entry count and the output valid; entries need no reset.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      is_insert;
  spq_op_t                   op;
  spq_link_t                 links [DEPTH+1];
  logic [CW+OCC_W-1:0]       occ_wide;

  logic                      rsp_valid;
  logic signed [VALUE_W-1:0] value_out;
  spq_status_t               status;
  logic [OCC_W-1:0]          occupancy;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_insert = (req.req_type == REQ_INSERT);

  assign op.ins = accept && is_insert && !full;
  assign op.rem = accept && !is_insert && !empty;
  assign op.key = req.value_in;

  assign links[0] = '{le: 1'b1, gt: 1'b0, value: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] right_value;
    if (i == DEPTH - 1) begin : g_last
      assign right_value = links[i+1].value;
    end else begin : g_mid
      assign right_value = links[i+2].value;
    end
    spq_cell u_cell (
      .clk         (clk),
      .valid       (CW'(i) < count),
      .op          (op),
      .left        (links[i]),
      .right_value (right_value),
      .link        (links[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.rem) begin
      count_next = count - 1'b1;
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= occ_wide[OCC_W-1:0];
      value_out <= '0;
      status    <= STATUS_OK;
      if (is_insert) begin
        if (full) begin
          status <= STATUS_FULL;
        end
      end else begin
        if (empty) begin
          status <= STATUS_EMPTY;
        end else begin
          value_out <= links[1].value;
        end
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.value_out = value_out;
  assign rsp.status    = status;
  assign rsp.occupancy = occupancy;

endmodule

### hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// Queue checker
// Port-level checks for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [spq_pkg::VALUE_W-1:0]  value_out,
  input logic [1:0]                          status,
  input logic [spq_pkg::OCC_W-1:0]           occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) &&
      $stable(status) && $stable(occupancy))
    else $error("Stalled result beat changed.");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted request produced no result beat.");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> occupancy == FULL_OCC && value_out == '0)
    else $error("Dropped insert reported a wrong occupancy or value.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_EMPTY |-> occupancy == '0 && value_out == '0)
    else $error("Remove on empty reported a wrong occupancy or value.");

endmodule

bind sorted_min_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .value_out (rsp.value_out),
  .status    (rsp.status),
  .occupancy (rsp.occupancy)
);

### test/sorted_min_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// Sorted minimum priority queue testbench
// Drives insert and remove requests through the request channel and checks
// every response beat against a sorted-list predictor kept in the bench.
// Directed cases cover the empty and full store, extreme values and ties.
// Random traffic follows, with bursty requests, receiver stalls, a long
// receiver hold-off that backs up the request channel, and a full drain.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int HOLD_LEN  = 300;
  localparam int MAX_CYCLE = 200000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    spq_status_t               status;
    logic [OCC_W-1:0]          occupancy;
  } spq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_min_priority_queue_top #(.DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic signed [VALUE_W-1:0] sorted_store[$];
  spq_result_t               pending_results[$];

  int failures       = 0;
  int cycle_count    = 0;
  int insert_count   = 0;
  int remove_count   = 0;
  int full_drops     = 0;
  int empty_removes  = 0;
  int peak_occupancy = 0;
  int hold_requests  = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.value_in = '0;
    rsp_if.ready    = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void predict_request(logic op, logic signed [VALUE_W-1:0] key);
    spq_result_t res;
    int          pos;
    res.value  = '0;
    res.status = STATUS_OK;
    if (op == REQ_INSERT) begin
      insert_count++;
      if (sorted_store.size() >= DEPTH) begin
        res.status = STATUS_FULL;
        full_drops++;
      end else begin
        pos = sorted_store.size();
        while (pos > 0 && sorted_store[pos-1] > key) pos--;
        sorted_store.insert(pos, key);
      end
    end else begin
      remove_count++;
      if (sorted_store.size() == 0) begin
        res.status = STATUS_EMPTY;
        empty_removes++;
      end else begin
        res.value = sorted_store.pop_front();
      end
    end
    res.occupancy = OCC_W'(sorted_store.size());
    if (sorted_store.size() > peak_occupancy) peak_occupancy = sorted_store.size();
    pending_results.push_back(res);
  endfunction

  function automatic void check_result();
    spq_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected response beat: value_out %0d status %0d occupancy %0d",
             rsp_if.value_out, rsp_if.status, rsp_if.occupancy);
      failures++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (rsp_if.value_out !== exp_res.value) begin
      $error("value_out: expected %0d, got %0d", exp_res.value, rsp_if.value_out);
      failures++;
    end
    if (rsp_if.status !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, rsp_if.status);
      failures++;
    end
    if (rsp_if.occupancy !== exp_res.occupancy) begin
      $error("occupancy: expected %0d, got %0d", exp_res.occupancy, rsp_if.occupancy);
      failures++;
    end
  endfunction

  // Requests are predicted before responses are checked, so a beat that
  // lands in the same cycle as a new request never sees a missing entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
        predict_request(req_if.req_type, req_if.value_in);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        check_result();
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    int stall_mode;
    int mode_cycles;
    int phase;
    hold_left   = 0;
    hold_seen   = 0;
    stall_mode  = 0;
    mode_cycles = 0;
    phase       = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_LEN;
      end
      if (mode_cycles == 0) begin
        stall_mode  = $urandom_range(0, 3);
        mode_cycles = $urandom_range(16, 96);
      end
      mode_cycles--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_if.ready <= (phase % 5 < 2);
          default: rsp_if.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  task automatic send_req(input logic op, input logic signed [VALUE_W-1:0] key);
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.value_in <= key;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_key();
    case ($urandom_range(0, 4))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 1000)) - 500;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic pick_op(input int insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
  endfunction

  task automatic test_empty_remove();
    send_req(REQ_REMOVE, 32'sd0);
    send_req(REQ_REMOVE, $signed($urandom()));
  endtask

  task automatic test_extreme_values();
    send_req(REQ_INSERT, 32'sh7fffffff);
    send_req(REQ_INSERT, 32'sh80000000);
    send_req(REQ_INSERT, -32'sd1);
    send_req(REQ_INSERT, 32'sd0);
    repeat (4) send_req(REQ_REMOVE, $signed($urandom()));
  endtask

  task automatic test_fill_and_overflow();
    send_req(REQ_INSERT, 32'sd7);
    send_req(REQ_INSERT, 32'sd7);
    send_req(REQ_INSERT, -32'sd7);
    repeat (DEPTH - 3) send_req(REQ_INSERT, random_key());
    send_req(REQ_INSERT, random_key());
    send_req(REQ_INSERT, 32'sh80000000);
  endtask

  task automatic test_random_traffic(input int item_total);
    int sent;
    int burst;
    int insert_pct;
    sent = 0;
    while (sent < item_total) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      repeat (burst) begin
        send_req(pick_op(insert_pct), random_key());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (40) send_req(pick_op(60), random_key());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_remove();
    test_extreme_values();
    test_fill_and_overflow();
    test_random_traffic(300);
    test_backpressure();
    wait_for_results();
    test_random_traffic(330);
    wait_for_results();
    repeat (10) @(negedge clk);

    $display("tb: %0d inserts (%0d dropped while full), %0d removes (%0d while empty)",
             insert_count, full_drops, remove_count, empty_removes);
    $display("tb: peak occupancy %0d of %0d, with stalls on both channels",
             peak_occupancy, DEPTH);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
